/* rtl/pida_pkg.sv */
// Package: shared types and constants for the positional insert/delete array.
`timescale 1ns / 1ps

package pida_pkg;

    localparam int DATA_W        = 32;
    localparam int POS_W         = 7;
    localparam int DEFAULT_DEPTH = 128;
    localparam int RD_GROUP      = 16;

    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_DELETE = 2'd1,
        FN_READ   = 2'd2,
        FN_CLEAR  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD_GROUP,
        S_RD_FINAL
    } state_t;

    typedef enum logic [1:0] {
        SH_HOLD,
        SH_INSERT,
        SH_DELETE
    } shift_t;

    typedef struct packed {
        shift_t                   shift;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] ins_value;
        logic [POS_W-1:0]         rd_pos;
    } cell_ctl_t;

endpackage

/* rtl/pida_cell.sv */
// One storage cell of the chain: holds an entry, shifts with its neighbours.
`timescale 1ns / 1ps

module pida_cell
    import pida_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic                     clk,
    input  cell_ctl_t                ctl,
    input  logic signed [DATA_W-1:0] left,
    input  logic signed [DATA_W-1:0] right,
    output logic signed [DATA_W-1:0] data,
    output logic signed [DATA_W-1:0] rd_tap
);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    int                       pos_i;
    int                       rd_i;

    always_comb
    begin
        pos_i     = int'(ctl.pos);
        rd_i      = int'(ctl.rd_pos);
        data_next = data_reg;
        case (ctl.shift)
            SH_INSERT:
            begin
                if (IDX == pos_i)
                begin
                    data_next = ctl.ins_value;
                end
                else if (IDX > pos_i)
                begin
                    data_next = left;
                end
            end
            SH_DELETE:
            begin
                if (IDX >= pos_i)
                begin
                    data_next = right;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data   = data_reg;
    assign rd_tap = (IDX == rd_i) ? data_reg : '0;

endmodule

/* rtl/pida_read_tree.sv */
// Read path: registered OR tree that gathers the selected cell's tap.
`timescale 1ns / 1ps

module pida_read_tree
    import pida_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH,
    parameter int GROUP = RD_GROUP
)
(
    input  logic                     clk,
    input  logic signed [DATA_W-1:0] taps [DEPTH],
    output logic signed [DATA_W-1:0] rd_data
);

    localparam int NG = (DEPTH + GROUP - 1) / GROUP;

    logic [DATA_W-1:0] group_reg  [NG];
    logic [DATA_W-1:0] group_next [NG];
    logic [DATA_W-1:0] acc;

    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            group_next[g] = '0;
            for (int i = 0; i < GROUP; i++)
            begin
                if (g * GROUP + i < DEPTH)
                begin
                    group_next[g] = group_next[g] | taps[g * GROUP + i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        group_reg <= group_next;
    end

    always_comb
    begin
        acc = '0;
        for (int g = 0; g < NG; g++)
        begin
            acc = acc | group_reg[g];
        end
    end

    assign rd_data = acc;

endmodule

/* rtl/positional_insert_delete_array.sv */
// Top level: ordered array of signed entries with insert, delete, read and clear.
`timescale 1ns / 1ps

// An item is taken when start is high and busy is low; its result appears on
// status, read_value and entry_count for one cycle with done high, and cannot
// be held off. For insert, delete, clear and any failed operation the result
// follows the accepting edge and busy stays low, so an item may be offered
// every cycle. A successful read passes through the registered read position
// and the register level inside the OR tree that gathers the addressed cell;
// busy is high in S_RD_GROUP and S_RD_FINAL after the read is taken. Entries
// live in a chain of DEPTH cells; the cells at and above the position change
// when an insert or delete is taken. No clearing pass is needed after reset.
module positional_insert_delete_array
    import pida_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               func,
    input  logic [POS_W-1:0]         position,
    input  logic signed [DATA_W-1:0] value,
    output logic                     done,
    output logic [1:0]               status,
    output logic signed [DATA_W-1:0] read_value,
    output logic [7:0]               entry_count
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam int WW   = (CW > 8) ? CW : 8;

    state_t                   state_reg;
    state_t                   state_next;
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic [POS_W-1:0]         rdpos_reg;
    logic [POS_W-1:0]         rdpos_next;
    logic                     done_reg;
    logic                     done_next;
    status_t                  status_reg;
    status_t                  status_next;
    logic signed [DATA_W-1:0] rdval_reg;
    logic signed [DATA_W-1:0] rdval_next;

    logic                     accept;
    logic                     read_go;
    logic [CMPW-1:0]          pos_x;
    logic [CMPW-1:0]          cnt_x;
    logic [WW-1:0]            cnt_wide;
    cell_ctl_t                ctl;
    shift_t                   shift;
    logic signed [DATA_W-1:0] cell_data [DEPTH];
    logic signed [DATA_W-1:0] taps      [DEPTH];
    logic signed [DATA_W-1:0] tree_out;

    assign accept = start && !busy;
    assign pos_x  = CMPW'(position);
    assign cnt_x  = CMPW'(count_reg);
    assign read_go = accept && (func_t'(func) == FN_READ) && (pos_x < cnt_x);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (read_go)
                begin
                    state_next = S_RD_GROUP;
                end
            end
            S_RD_GROUP:
            begin
                state_next = S_RD_FINAL;
            end
            S_RD_FINAL:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy        = (state_reg != S_IDLE);
        shift       = SH_HOLD;
        count_next  = count_reg;
        rdpos_next  = rdpos_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        rdval_next  = rdval_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    rdval_next  = '0;
                    case (func_t'(func))
                        FN_INSERT:
                        begin
                            if (pos_x > cnt_x)
                            begin
                                status_next = ST_BADPOS;
                            end
                            else if (count_reg == CW'(DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                shift      = SH_INSERT;
                                count_next = CW'(count_reg + 1'b1);
                            end
                        end
                        FN_DELETE:
                        begin
                            if (pos_x >= cnt_x)
                            begin
                                status_next = ST_BADPOS;
                            end
                            else
                            begin
                                shift      = SH_DELETE;
                                count_next = CW'(count_reg - 1'b1);
                            end
                        end
                        FN_READ:
                        begin
                            if (pos_x >= cnt_x)
                            begin
                                status_next = ST_BADPOS;
                            end
                            else
                            begin
                                done_next  = 1'b0;
                                rdpos_next = position;
                            end
                        end
                        default:
                        begin
                            count_next = '0;
                        end
                    endcase
                end
            end
            S_RD_FINAL:
            begin
                done_next   = 1'b1;
                status_next = ST_OK;
                rdval_next  = tree_out;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rdpos_reg  <= rdpos_next;
        status_reg <= status_next;
        rdval_reg  <= rdval_next;
    end

    assign ctl.shift     = shift;
    assign ctl.pos       = position;
    assign ctl.ins_value = value;
    assign ctl.rd_pos    = rdpos_reg;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            pida_cell #(
                .IDX (gi)
            ) u_cell (
                .clk    (clk),
                .ctl    (ctl),
                .left   ((gi == 0) ? value : cell_data[(gi == 0) ? 0 : gi - 1]),
                .right  ((gi == DEPTH - 1) ? '0
                         : cell_data[(gi == DEPTH - 1) ? gi : gi + 1]),
                .data   (cell_data[gi]),
                .rd_tap (taps[gi])
            );
        end
    endgenerate

    pida_read_tree #(
        .DEPTH (DEPTH),
        .GROUP (RD_GROUP)
    ) u_read_tree (
        .clk     (clk),
        .taps    (taps),
        .rd_data (tree_out)
    );

    assign cnt_wide    = WW'(count_reg);
    assign done        = done_reg;
    assign status      = status_reg;
    assign read_value  = rdval_reg;
    assign entry_count = cnt_wide[7:0];

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (status_reg == ST_FULL) |-> count_reg == CW'(DEPTH))
        else $error("full reported while space remains");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (status_reg != ST_OK) |-> rdval_reg == '0)
        else $error("failed item returned a non-zero value");

    a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
        read_go |=> ##1 done_next)
        else $error("read result not produced on time");

endmodule

/* tb/positional_insert_delete_array_checker.sv */
// Checker: predicts each array operation result and compares it with the block output.
`timescale 1ns / 1ps

module positional_insert_delete_array_checker
    import pida_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic [1:0]               func,
    input  logic [POS_W-1:0]         position,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     done,
    input  logic [1:0]               status,
    input  logic signed [DATA_W-1:0] read_value,
    input  logic [7:0]               entry_count,
    output int                       errors,
    output int                       pending
);

    typedef struct packed {
        status_t                  status;
        logic signed [DATA_W-1:0] read_value;
        logic [7:0]               entry_count;
    } op_result_t;

    logic signed [DATA_W-1:0] array_image [DEPTH];
    int                       image_count = 0;
    int                       fail_count  = 0;
    op_result_t               awaited_results [$];
    op_result_t               oldest;

    assign errors = fail_count;

    function automatic op_result_t apply_operation(func_t op, logic [POS_W-1:0] pos,
                                                   logic signed [DATA_W-1:0] val);
        op_result_t res;
        int         p;
        int         i;
        p              = int'(pos);
        res.status     = ST_OK;
        res.read_value = '0;
        case (op)
            FN_INSERT:
            begin
                if (p > image_count)
                    res.status = ST_BADPOS;
                else if (image_count >= DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    for (i = image_count; i > p; i--)
                        array_image[i] = array_image[i-1];
                    array_image[p] = val;
                    image_count++;
                end
            end
            FN_DELETE:
            begin
                if (p >= image_count)
                    res.status = ST_BADPOS;
                else
                begin
                    for (i = p; i + 1 < image_count; i++)
                        array_image[i] = array_image[i+1];
                    image_count--;
                end
            end
            FN_READ:
            begin
                if (p >= image_count)
                    res.status = ST_BADPOS;
                else
                    res.read_value = array_image[p];
            end
            default:
            begin
                image_count = 0;
            end
        endcase
        res.entry_count = 8'(image_count);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaited_results.delete();
            image_count = 0;
            pending <= 0;
        end
        else
        begin
            if (done)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: unexpected result: status %0d read_value %0d entry_count %0d",
                             $time, status, read_value, entry_count);
                    fail_count++;
                end
                else
                begin
                    oldest = awaited_results.pop_front();
                    if (status !== oldest.status)
                    begin
                        $display("%0t: status expected %0d, actual %0d",
                                 $time, oldest.status, status);
                        fail_count++;
                    end
                    if (read_value !== oldest.read_value)
                    begin
                        $display("%0t: read_value expected %0d, actual %0d",
                                 $time, oldest.read_value, read_value);
                        fail_count++;
                    end
                    if (entry_count !== oldest.entry_count)
                    begin
                        $display("%0t: entry_count expected %0d, actual %0d",
                                 $time, oldest.entry_count, entry_count);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                awaited_results.push_back(apply_operation(func_t'(func), position, value));
            pending <= awaited_results.size();
        end
    end

endmodule

/* tb/positional_insert_delete_array_tb.sv */
// Testbench top: drives array operations into the block and reports the verdict.
`timescale 1ns / 1ps

module positional_insert_delete_array_tb;
    import pida_pkg::*;

    localparam int DEPTH         = DEFAULT_DEPTH;
    localparam int ITEM_TARGET   = 900;
    localparam int STALL_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = 4;
    localparam int POS_MAX       = (1 << POS_W) - 1;

    typedef enum {
        MIX_GROW,
        MIX_SHRINK,
        MIX_BALANCED,
        MIX_NOISE
    } mix_t;

    logic                     clk;
    logic                     rst_n    = 1'b0;
    logic                     start    = 1'b0;
    logic                     busy;
    logic [1:0]               func     = FN_CLEAR;
    logic [POS_W-1:0]         position = '0;
    logic signed [DATA_W-1:0] value    = '0;
    logic                     done;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] read_value;
    logic [7:0]               entry_count;

    int errors;
    int pending;
    int idle_cycles = 0;
    int fill        = 0;
    int items_sent  = 0;
    int full_hits   = 0;
    int rejects     = 0;
    int burst_left  = 1;
    int op_counts [4];

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    positional_insert_delete_array #(.DEPTH(DEPTH)) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .position   (position),
        .value      (value),
        .done       (done),
        .status     (status),
        .read_value (read_value),
        .entry_count(entry_count)
    );

    positional_insert_delete_array_checker #(.DEPTH(DEPTH)) result_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .position   (position),
        .value      (value),
        .done       (done),
        .status     (status),
        .read_value (read_value),
        .entry_count(entry_count),
        .errors     (errors),
        .pending    (pending)
    );

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("positional_insert_delete_array_tb: errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic issue(func_t op, logic [POS_W-1:0] pos, logic signed [DATA_W-1:0] val);
        int p;
        p        = int'(pos);
        start    <= 1'b1;
        func     <= op;
        position <= pos;
        value    <= val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
        op_counts[int'(op)]++;
        case (op)
            FN_INSERT:
            begin
                if (p > fill)
                    rejects++;
                else if (fill >= DEPTH)
                    full_hits++;
                else
                    fill++;
            end
            FN_DELETE:
            begin
                if (p >= fill)
                    rejects++;
                else
                    fill--;
            end
            FN_READ:
            begin
                if (p >= fill)
                    rejects++;
            end
            default:
            begin
                fill = 0;
            end
        endcase
    endtask

    task automatic pace();
        int gap;
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 50);
        end
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        if ($urandom_range(0, 15) != 0)
            return $urandom;
        case ($urandom_range(0, 3))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    task automatic random_item(mix_t mix);
        int               r;
        int               top_pos;
        func_t            op;
        logic [POS_W-1:0] pos;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_GROW:
                op = (r < 85) ? FN_INSERT : (r < 95) ? FN_READ : FN_DELETE;
            MIX_SHRINK:
                op = (r < 65) ? FN_DELETE : (r < 85) ? FN_READ :
                     (r < 98) ? FN_INSERT : FN_CLEAR;
            MIX_BALANCED:
                op = (r < 40) ? FN_INSERT : (r < 65) ? FN_DELETE :
                     (r < 97) ? FN_READ : FN_CLEAR;
            default:
                op = func_t'($urandom_range(0, 3));
        endcase
        top_pos = (op == FN_INSERT) ? fill : fill - 1;
        if (top_pos > POS_MAX)
            top_pos = POS_MAX;
        if (mix == MIX_NOISE || top_pos < 0 || $urandom_range(0, 9) == 0)
            pos = POS_W'($urandom_range(0, POS_MAX));
        else if ($urandom_range(0, 7) == 0)
            pos = ($urandom_range(0, 1) == 0) ? '0 : POS_W'(top_pos);
        else
            pos = POS_W'($urandom_range(0, top_pos));
        issue(op, pos, pick_value());
        pace();
    endtask

    initial
    begin
        mix_t mix;
        int   len;
        int   r;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(FN_READ,   7'd0,   32'sd0);
        issue(FN_DELETE, 7'd0,   32'sd0);
        issue(FN_INSERT, 7'd1,   32'sd5);
        issue(FN_INSERT, 7'd127, -32'sd1);
        issue(FN_INSERT, 7'd0,   32'sh7FFF_FFFF);
        issue(FN_INSERT, 7'd1,   32'sh8000_0000);
        issue(FN_INSERT, 7'd0,   -32'sd1);
        issue(FN_INSERT, 7'd3,   32'sd0);
        issue(FN_INSERT, 7'd2,   32'sh1234_5678);
        for (int i = 0; i < 5; i++)
            issue(FN_READ, POS_W'(i), $urandom);
        issue(FN_READ,   7'd5,   32'sd0);
        issue(FN_DELETE, 7'd5,   32'sd0);
        issue(FN_DELETE, 7'd2,   32'sd0);
        issue(FN_DELETE, 7'd0,   32'sd0);
        issue(FN_READ,   7'd0,   32'sd0);
        issue(FN_READ,   7'd2,   32'sd0);
        issue(FN_INSERT, 7'd4,   32'sd9);
        issue(FN_CLEAR,  7'd127, -32'sd1);
        issue(FN_READ,   7'd0,   32'sd0);
        issue(FN_DELETE, 7'd0,   32'sd0);
        issue(FN_INSERT, 7'd0,   32'sd0);
        wait_for_results();

        burst_left = $urandom_range(1, 50);
        while (fill < DEPTH)
            random_item(MIX_GROW);
        while (items_sent < ITEM_TARGET)
        begin
            r   = $urandom_range(0, 9);
            mix = (r < 4) ? MIX_GROW : (r < 6) ? MIX_SHRINK :
                  (r < 9) ? MIX_BALANCED : MIX_NOISE;
            len = $urandom_range(20, 80);
            repeat (len) random_item(mix);
            if ($urandom_range(0, 3) == 0)
                wait_for_results();
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d operations sent: %0d insert, %0d delete, %0d read, %0d clear",
                 items_sent, op_counts[FN_INSERT], op_counts[FN_DELETE],
                 op_counts[FN_READ], op_counts[FN_CLEAR]);
        $display("%0d inserts refused on a full array, %0d operations at a bad position",
                 full_hits, rejects);
        if (errors == 0 && pending == 0)
            $display("positional_insert_delete_array_tb: clean");
        else
            $display("positional_insert_delete_array_tb: errors");
        $finish;
    end

endmodule

/* positional_insert_delete_array.f */
rtl/pida_pkg.sv
rtl/pida_cell.sv
rtl/pida_read_tree.sv
rtl/positional_insert_delete_array.sv
tb/positional_insert_delete_array_checker.sv
tb/positional_insert_delete_array_tb.sv
